// File: rtl/lr_pkg.sv
// shared types and constants for the line rasterizer
`timescale 1ns / 1ps

package lr_pkg;

    localparam int X_W     = 9;
    localparam int Y_W     = 8;
    localparam int COLOR_W = 16;
    localparam int ADDR_W  = 32;
    localparam int ERR_W   = 10;

    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 72;

    localparam logic [ADDR_W-1:0] BUFFER_BASE_RESET = 32'hC800_0000;

    typedef enum logic {
        CMD_START   = 1'b0,
        CMD_ADVANCE = 1'b1
    } cmd_t;

    // line geometry along the major and minor axes
    typedef struct packed {
        logic                    steep;
        logic [X_W-1:0]          major_pos;
        logic [X_W-1:0]          minor_pos;
        logic [X_W-1:0]          major_end;
        logic [X_W-1:0]          major_delta;
        logic [X_W-1:0]          minor_delta;
        logic                    minor_step_down;
        logic signed [ERR_W-1:0] error_term;
    } line_geom_t;

endpackage

// File: rtl/lr_setup.sv
// line setup: axis swap, endpoint ordering and initial error term
`timescale 1ns / 1ps

module lr_setup
    import lr_pkg::*;
(
    input  logic [X_W-1:0] start_x,
    input  logic [Y_W-1:0] start_y,
    input  logic [X_W-1:0] end_x,
    input  logic [Y_W-1:0] end_y,
    output line_geom_t     geom
);

    logic [X_W-1:0] adx;
    logic [Y_W-1:0] ady;
    logic           steep;
    logic [X_W-1:0] a0;
    logic [X_W-1:0] b0;
    logic [X_W-1:0] a1;
    logic [X_W-1:0] b1;
    logic [X_W-1:0] lo_a;
    logic [X_W-1:0] lo_b;
    logic [X_W-1:0] hi_a;
    logic [X_W-1:0] hi_b;
    logic [X_W-1:0] maj_d;

    always_comb
    begin
        adx   = (end_x >= start_x) ? end_x - start_x : start_x - end_x;
        ady   = (end_y >= start_y) ? end_y - start_y : start_y - end_y;
        steep = {1'b0, ady} > adx;

        if (steep)
        begin
            a0 = {1'b0, start_y};
            b0 = start_x;
            a1 = {1'b0, end_y};
            b1 = end_x;
        end
        else
        begin
            a0 = start_x;
            b0 = {1'b0, start_y};
            a1 = end_x;
            b1 = {1'b0, end_y};
        end

        // order so the major coordinate rises
        if (a0 > a1)
        begin
            lo_a = a1;
            lo_b = b1;
            hi_a = a0;
            hi_b = b0;
        end
        else
        begin
            lo_a = a0;
            lo_b = b0;
            hi_a = a1;
            hi_b = b1;
        end

        maj_d = hi_a - lo_a;

        geom.steep           = steep;
        geom.major_pos       = lo_a;
        geom.minor_pos       = lo_b;
        geom.major_end       = hi_a;
        geom.major_delta     = maj_d;
        geom.minor_delta     = (hi_b > lo_b) ? hi_b - lo_b : lo_b - hi_b;
        geom.minor_step_down = !(lo_b < hi_b);
        geom.error_term      = ERR_W'(0) - {2'b00, maj_d[X_W-1:1]};
    end

endmodule

// File: rtl/line_rasterizer.sv
// top level of the bresenham line rasterizer
`timescale 1ns / 1ps
// latency: a pixel item reaches m_tvalid after passing the input register and then the result register
// throughput: one item per cycle while m_tready holds, set by the single-pass step stage
// an input register and a result register let an item in while a pixel waits
// reset: asynchronous, active low; clears both stages, drops any line and
// loads buffer_base with 0xC8000000

module line_rasterizer
    import lr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    // buffer_base register write
    input  logic                  cfg_wen,
    input  logic [ADDR_W-1:0]     cfg_wdata,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    // start_x[8:0], start_y[16:9], end_x[25:17], end_y[33:26], color[49:34], zero fill
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // cmd
    input  logic                  s_tuser,

    output logic                  m_tvalid,
    input  logic                  m_tready,
    // pixel_x[8:0], pixel_y[16:9], pixel_color[32:17], pixel_address[64:33], zero fill
    output logic [OUT_DATA_W-1:0] m_tdata,
    // last_pixel
    output logic                  m_tlast
);

    // configuration
    logic [ADDR_W-1:0]  base_reg;

    // input stage
    logic               in_valid_reg;
    cmd_t               cmd_reg;
    logic [X_W-1:0]     start_x_reg;
    logic [Y_W-1:0]     start_y_reg;
    logic [X_W-1:0]     end_x_reg;
    logic [Y_W-1:0]     end_y_reg;
    logic [COLOR_W-1:0] color_reg;

    // line state
    logic               line_active_reg;
    logic               line_active_next;
    line_geom_t         geom_reg;
    line_geom_t         geom_next;
    logic [COLOR_W-1:0] line_color_reg;

    // result stage
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [X_W-1:0]     px_reg;
    logic [Y_W-1:0]     py_reg;
    logic [COLOR_W-1:0] pcolor_reg;
    logic [ADDR_W-1:0]  paddr_reg;
    logic               plast_reg;

    // step stage
    line_geom_t              setup_geom;
    line_geom_t              cur_geom;
    logic [COLOR_W-1:0]      cur_color;
    logic                    is_start;
    logic                    proc_fire;
    logic                    emit;
    logic                    last;
    logic [X_W-1:0]          px;
    logic [Y_W-1:0]          py;
    logic [ADDR_W-1:0]       paddr;
    logic signed [ERR_W:0]   err_sum;
    logic signed [ERR_W:0]   err_new;
    logic                    minor_step;

    lr_setup u_setup
    (
        .start_x (start_x_reg),
        .start_y (start_y_reg),
        .end_x   (end_x_reg),
        .end_y   (end_y_reg),
        .geom    (setup_geom)
    );

    // the step stage runs when the result register is free or draining
    assign proc_fire = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || proc_fire;

    always_comb
    begin
        is_start  = (cmd_reg == CMD_START);
        cur_geom  = is_start ? setup_geom : geom_reg;
        cur_color = is_start ? color_reg : line_color_reg;
        emit      = is_start || line_active_reg;
        last      = (cur_geom.major_pos == cur_geom.major_end);

        // map major and minor back to screen axes
        px    = cur_geom.steep ? cur_geom.minor_pos : cur_geom.major_pos;
        py    = cur_geom.steep ? cur_geom.major_pos[Y_W-1:0] : cur_geom.minor_pos[Y_W-1:0];
        paddr = base_reg + {14'b0, py, 10'b0} + {22'b0, px, 1'b0};

        // one bresenham step
        err_sum    = {cur_geom.error_term[ERR_W-1], cur_geom.error_term}
                     + {2'b00, cur_geom.minor_delta};
        minor_step = !err_sum[ERR_W] && (err_sum != '0);
        err_new    = minor_step ? err_sum - {2'b00, cur_geom.major_delta} : err_sum;

        geom_next = cur_geom;
        if (!last)
        begin
            geom_next.major_pos  = cur_geom.major_pos + X_W'(1);
            geom_next.error_term = err_new[ERR_W-1:0];
            if (minor_step)
            begin
                geom_next.minor_pos = cur_geom.minor_step_down
                                      ? cur_geom.minor_pos - X_W'(1)
                                      : cur_geom.minor_pos + X_W'(1);
            end
        end
        line_active_next = !last;

        // result register empties when taken, loads when a pixel comes out
        out_valid_next = out_valid_reg && !m_tready;
        if (proc_fire && emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    // control and line state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg        <= BUFFER_BASE_RESET;
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            line_active_reg <= 1'b0;
            geom_reg        <= '0;
            line_color_reg  <= '0;
        end
        else
        begin
            if (cfg_wen)
            begin
                base_reg <= cfg_wdata;
            end
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            out_valid_reg <= out_valid_next;
            if (proc_fire && emit)
            begin
                line_active_reg <= line_active_next;
                geom_reg        <= geom_next;
                line_color_reg  <= cur_color;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            cmd_reg     <= cmd_t'(s_tuser);
            start_x_reg <= s_tdata[8:0];
            start_y_reg <= s_tdata[16:9];
            end_x_reg   <= s_tdata[25:17];
            end_y_reg   <= s_tdata[33:26];
            color_reg   <= s_tdata[49:34];
        end
        if (proc_fire && emit)
        begin
            px_reg     <= px;
            py_reg     <= py;
            pcolor_reg <= cur_color;
            paddr_reg  <= paddr;
            plast_reg  <= last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, paddr_reg, pcolor_reg, py_reg, px_reg};
    assign m_tlast  = plast_reg;

`ifndef SYNTHESIS
    // the error term stays within (-major_delta, 0] while a line runs
    assert property (@(posedge clk) disable iff (!rst_n)
        line_active_reg |-> (geom_reg.error_term <= 0)
            && ($signed({1'b0, geom_reg.major_delta}) + geom_reg.error_term > 0))
        else $error("error term out of range");

    // an active line never walks past its end point
    assert property (@(posedge clk) disable iff (!rst_n)
        line_active_reg |-> (geom_reg.major_pos <= geom_reg.major_end))
        else $error("major position beyond end point");

    // the minor axis never moves further than the major one
    assert property (@(posedge clk) disable iff (!rst_n)
        line_active_reg |-> (geom_reg.minor_delta <= geom_reg.major_delta))
        else $error("minor delta exceeds major delta");

    // the last pixel of a line ends it
    assert property (@(posedge clk) disable iff (!rst_n)
        (proc_fire && emit && last) |=> !line_active_reg)
        else $error("line still active after last pixel");

    // an advance with no line leaves nothing in the result register
    assert property (@(posedge clk) disable iff (!rst_n)
        (proc_fire && !emit && (!out_valid_reg || m_tready)) |=> !m_tvalid)
        else $error("pixel from advance with no line");
`endif

endmodule

// File: bench/lr_check_pkg.sv
// pixel prediction and scoreboard for the line rasterizer bench
`timescale 1ns / 1ps

package lr_check_pkg;

    import lr_pkg::*;

    typedef struct {
        logic [X_W-1:0]     x;
        logic [Y_W-1:0]     y;
        logic [COLOR_W-1:0] colour;
        logic [ADDR_W-1:0]  addr;
        logic               last;
    } pixel_t;

    class pixel_scoreboard;

        logic [ADDR_W-1:0]  buffer_base = BUFFER_BASE_RESET;
        bit                 line_on;
        bit                 steep;
        logic [X_W-1:0]     major_pos;
        logic [X_W-1:0]     minor_pos;
        logic [X_W-1:0]     major_end;
        logic [X_W-1:0]     major_span;
        logic [X_W-1:0]     minor_span;
        bit                 minor_down;
        int                 err_acc;
        logic [COLOR_W-1:0] line_colour;

        pixel_t pixel_q[$];
        int     failures;

        function new();
        endfunction

        function int pending();
            return pixel_q.size();
        endfunction

        // work out the pixel that an accepted item causes, if any
        function void note_item(cmd_t cmd, logic [X_W-1:0] sx, logic [Y_W-1:0] sy,
                                logic [X_W-1:0] ex, logic [Y_W-1:0] ey,
                                logic [COLOR_W-1:0] colour);
            int     x0, y0, x1, y1, a0, b0, a1, b1, t, adx, ady, e;
            pixel_t p;
            if (cmd == CMD_START) begin
                x0 = sx;
                y0 = sy;
                x1 = ex;
                y1 = ey;
                adx = x1 > x0 ? x1 - x0 : x0 - x1;
                ady = y1 > y0 ? y1 - y0 : y0 - y1;
                steep = ady > adx;
                if (steep) begin
                    a0 = y0; b0 = x0; a1 = y1; b1 = x1;
                end
                else begin
                    a0 = x0; b0 = y0; a1 = x1; b1 = y1;
                end
                if (a0 > a1) begin
                    t = a0; a0 = a1; a1 = t;
                    t = b0; b0 = b1; b1 = t;
                end
                major_pos   = a0[X_W-1:0];
                minor_pos   = b0[X_W-1:0];
                major_end   = a1[X_W-1:0];
                major_span  = X_W'(a1 - a0);
                minor_span  = X_W'(b1 > b0 ? b1 - b0 : b0 - b1);
                minor_down  = !(b0 < b1);
                err_acc     = -(int'(major_span) / 2);
                line_colour = colour;
            end
            else if (!line_on) begin
                return;
            end
            p.x      = steep ? minor_pos : major_pos;
            p.y      = steep ? major_pos[Y_W-1:0] : minor_pos[Y_W-1:0];
            p.colour = line_colour;
            p.addr   = buffer_base + (ADDR_W'(p.y) << 10) + (ADDR_W'(p.x) << 1);
            p.last   = (major_pos == major_end);
            pixel_q.push_back(p);
            if (p.last) begin
                line_on = 0;
            end
            else begin
                line_on = 1;
                e = err_acc + int'(minor_span);
                if (e > 0) begin
                    minor_pos = minor_down ? minor_pos - 1'b1 : minor_pos + 1'b1;
                    e -= int'(major_span);
                end
                err_acc   = e;
                major_pos = major_pos + 1'b1;
            end
        endfunction

        // compare an accepted pixel with the oldest one waiting
        function void check_pixel(pixel_t got);
            pixel_t want;
            if (pixel_q.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("unexpected pixel x=%0d y=%0d colour=%h addr=%h last=%b",
                             got.x, got.y, got.colour, got.addr, got.last);
                return;
            end
            want = pixel_q.pop_front();
            if (got.x !== want.x || got.y !== want.y || got.colour !== want.colour ||
                got.addr !== want.addr || got.last !== want.last) begin
                failures++;
                if (failures <= 10)
                    $display("pixel mismatch: want x=%0d y=%0d colour=%h addr=%h last=%b, got x=%0d y=%0d colour=%h addr=%h last=%b",
                             want.x, want.y, want.colour, want.addr, want.last,
                             got.x, got.y, got.colour, got.addr, got.last);
            end
        endfunction

    endclass

endpackage

// File: bench/line_rasterizer_tb.sv
// stimulus, checking and run control for the line rasterizer
`timescale 1ns / 1ps

module line_rasterizer_tb;

    import lr_pkg::*;
    import lr_check_pkg::*;

    // generous cycle budget: every item waiting out the longest gap and stall
    localparam int CYCLE_LIMIT = 400000;
    // long receiver hold-off so the pipeline fills and s_tready drops
    localparam int HOLD_CYCLES = 60;
    // settle time before a register write
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_ITEMS = 100;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wen;
    logic [ADDR_W-1:0]     cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    // start_x, start_y, end_x, end_y, color, zero fill
    logic [IN_DATA_W-1:0]  s_tdata;
    // cmd
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    // pixel_x, pixel_y, pixel_color, pixel_address, zero fill
    logic [OUT_DATA_W-1:0] m_tdata;
    // last_pixel
    logic                  m_tlast;

    pixel_scoreboard sb = new();

    // idling on both sides is switched off for the last part of the run
    bit idling_on = 1;
    // set by the stimulus to ask the receiver for one long hold-off
    bit hold_request = 0;
    int cycle_count = 0;

    line_rasterizer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // offer one item and hold it until the block takes it
    task automatic send_item(cmd_t cmd, logic [X_W-1:0] sx, logic [Y_W-1:0] sy,
                             logic [X_W-1:0] ex, logic [Y_W-1:0] ey,
                             logic [COLOR_W-1:0] colour);
        int gap;
        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 11);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {6'b0, colour, ey, ex, sy, sx};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_item(cmd, sx, sy, ex, ey, colour);
    endtask

    // advance item; the endpoint and colour fields carry noise the block must ignore
    task automatic send_advance();
        send_item(CMD_ADVANCE, X_W'($urandom), Y_W'($urandom), X_W'($urandom),
                  Y_W'($urandom), COLOR_W'($urandom));
    endtask

    task automatic send_segment(logic [X_W-1:0] sx, logic [Y_W-1:0] sy,
                                logic [X_W-1:0] ex, logic [Y_W-1:0] ey,
                                logic [COLOR_W-1:0] colour, int steps);
        send_item(CMD_START, sx, sy, ex, ey, colour);
        repeat (steps) send_advance();
    endtask

    // drop valid and let every expected pixel drain out of the block
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_base(logic [ADDR_W-1:0] value);
        wait_idle();
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_wen   <= 1'b0;
        sb.buffer_base = value;
    endtask

    // mostly short well-formed lines, a few long ones, some abandoned part-way
    // and some followed by advances that find no active line
    task automatic random_lines(int budget);
        int sent, x0, y0, x1, y1, adx, ady, steps;
        sent = 0;
        while (sent < budget)
        begin
            x0 = $urandom_range(0, 511);
            y0 = $urandom_range(0, 255);
            if ($urandom_range(0, 99) < 3)
            begin
                x1 = $urandom_range(0, 511);
                y1 = $urandom_range(0, 255);
            end
            else
            begin
                x1 = x0 + int'($urandom_range(0, 24)) - 12;
                y1 = y0 + int'($urandom_range(0, 24)) - 12;
                x1 = x1 < 0 ? 0 : (x1 > 511 ? 511 : x1);
                y1 = y1 < 0 ? 0 : (y1 > 255 ? 255 : y1);
            end
            adx = x1 > x0 ? x1 - x0 : x0 - x1;
            ady = y1 > y0 ? y1 - y0 : y0 - y1;
            steps = adx > ady ? adx : ady;
            // long lines are cut short more often to keep the run brief
            if ($urandom_range(0, 9) == 0 || (steps > 40 && $urandom_range(0, 1) == 0))
                steps = $urandom_range(0, steps);
            // keep the phase close to its item budget
            if (steps > budget - sent - 1)
                steps = budget - sent - 1;
            send_segment(X_W'(x0), Y_W'(y0), X_W'(x1), Y_W'(y1), COLOR_W'($urandom), steps);
            sent += 1 + steps;
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 2)) send_advance();
        end
    endtask

    // receiver: random stalls, free-running stretches and one long hold-off
    initial
    begin
        m_tready <= 1'b0;
        repeat (6) @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (idling_on && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
        end
    end

    // output monitor: every accepted pixel goes to the scoreboard
    always @(posedge clk)
    begin
        pixel_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.x      = m_tdata[8:0];
            got.y      = m_tdata[16:9];
            got.colour = m_tdata[32:17];
            got.addr   = m_tdata[64:33];
            got.last   = m_tlast;
            sb.check_pixel(got);
        end
    end

    // watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    initial
    begin
        rst_n     <= 1'b0;
        cfg_wen   <= 1'b0;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= CMD_START;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, buffer base left at its reset value
        // advance straight after reset: nothing active, no pixel
        send_advance();
        // single-point lines at both corners of the field range
        send_segment(9'd0, 8'd0, 9'd0, 8'd0, 16'h0000, 0);
        send_segment(9'd511, 8'd255, 9'd511, 8'd255, 16'hFFFF, 0);
        // flat line to the right
        send_segment(9'd0, 8'd0, 9'd3, 8'd0, 16'h1234, 3);
        // steep line, minor axis stepping down
        send_segment(9'd5, 8'd0, 9'd3, 8'd4, 16'hA5A5, 4);
        // shallow line given back to front, endpoints get swapped
        send_segment(9'd4, 8'd2, 9'd0, 8'd0, 16'h5A5A, 4);
        // advance after the end point has been emitted
        send_advance();
        // diagonal, abandoned after two pixels by a new start
        send_segment(9'd0, 8'd0, 9'd2, 8'd2, 16'h0F0F, 1);
        // vertical line given upwards, endpoints get swapped; replaces the unfinished diagonal
        send_segment(9'd10, 8'd3, 9'd10, 8'd0, 16'hF0F0, 3);

        // random phases, each under a different buffer base
        write_base(32'h0000_0000);
        hold_request = 1;
        random_lines(PHASE_ITEMS);
        write_base(32'hFFFF_FFFF);
        random_lines(PHASE_ITEMS);
        // base near the top so large rows wrap the address
        write_base(32'hFFFF_0000);
        random_lines(PHASE_ITEMS);
        write_base(ADDR_W'($urandom));
        random_lines(PHASE_ITEMS);
        // last part at full rate on both sides
        write_base(ADDR_W'($urandom));
        idling_on = 0;
        random_lines(PHASE_ITEMS);

        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
